[rtl/core/tbvs_pkg.sv]
package tbvs_pkg;

	localparam int MAX_NODES_DEF = 64;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int NODE_W     = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_SQUARED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BOUNDARY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BOUNDARY   = 2'd2;

	localparam logic [30:0]        INV_STEP_SQUARED_RST = 31'd26354647;
	localparam logic signed [31:0] LEFT_BOUNDARY_RST    = 32'sd131072;
	localparam logic signed [31:0] RIGHT_BOUNDARY_RST   = 32'sd196608;

	typedef struct packed {
		logic signed [31:0] rhs_sample;
		logic               final_sample;
	} in_item_t;

	typedef struct packed {
		logic [NODE_W-1:0]  node_number;
		logic signed [31:0] solution_value;
		logic               run_end;
	} result_t;

	typedef struct packed {
		logic [30:0]        inv_step_squared;
		logic signed [31:0] left_boundary;
		logic signed [31:0] right_boundary;
	} cfg_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MULA,
		B_MULB,
		B_PREP,
		B_DIV,
		B_WR,
		B_RDY,
		B_MULY,
		B_OUT
	} back_state_t;

endpackage

[rtl/core/tbvs_ram.sv]
module tbvs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/tbvs_front.sv]
module tbvs_front #(
	parameter int MAX_NODES = tbvs_pkg::MAX_NODES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  tbvs_pkg::in_item_t           in_item,
	output logic                         head_valid,
	output logic signed [31:0]           head_rhs,
	output logic [$clog2(MAX_NODES)-1:0] head_idx,
	output logic                         head_last,
	input  logic                         head_pop
);
	import tbvs_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_NODES - 2);

	logic [IW-1:0]      count_q;
	logic [IW-1:0]      idx;
	logic               last;
	logic               accept;
	logic signed [31:0] q_rhs_q  [2];
	logic [IW-1:0]      q_idx_q  [2];
	logic               q_last_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         fill_q;

	// The node index and the closing decision are settled here, so the
	// back end only sees fully classified transactions.
	assign idx    = count_q + IW'(1);
	assign last   = in_item.final_sample || (idx == LAST_IDX);
	assign busy   = (fill_q == 2'd2);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept) begin
				count_q  <= last ? '0 : idx;
				wr_ptr_q <= !wr_ptr_q;
			end
			if (head_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(accept) - 2'(head_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_rhs_q[wr_ptr_q]  <= in_item.rhs_sample;
			q_idx_q[wr_ptr_q]  <= idx;
			q_last_q[wr_ptr_q] <= last;
		end
	end

	assign head_valid = (fill_q != 2'd0);
	assign head_rhs   = q_rhs_q[rd_ptr_q];
	assign head_idx   = q_idx_q[rd_ptr_q];
	assign head_last  = q_last_q[rd_ptr_q];

endmodule

[rtl/core/tbvs_back.sv]
module tbvs_back #(
	parameter int MAX_NODES = tbvs_pkg::MAX_NODES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tbvs_pkg::cfg_t               cfg,
	input  logic                         head_valid,
	input  logic signed [31:0]           head_rhs,
	input  logic [$clog2(MAX_NODES)-1:0] head_idx,
	input  logic                         head_last,
	output logic                         head_pop,
	output logic                         result_strobe,
	output tbvs_pkg::result_t            result
);
	import tbvs_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	back_state_t state_q, state_d;

	logic signed [31:0] rhs_q;
	logic [IW-1:0]      idx_q;
	logic               last_q;
	logic [30:0]        k_q;
	logic signed [31:0] left_q;
	logic signed [31:0] right_q;
	logic signed [63:0] prod_q;
	logic signed [48:0] den_q;
	logic [64:0]        rem_a_q, rem_b_q;
	logic [79:0]        dsh_q;
	logic [31:0]        quo_a_q, quo_b_q;
	logic [4:0]         step_q;
	logic               neg_a_q, neg_b_q, sat_a_q, sat_b_q, zr_a_q, zr_b_q;
	logic signed [31:0] back_q;
	logic [IW-1:0]      bidx_q;

	logic [IW-1:0]      rd_addr;
	logic [63:0]        rd_data;
	logic               ram_we;
	logic signed [31:0] prev_a, prev_b, sel_a, sel_b;
	logic signed [31:0] res_a, res_b;
	logic signed [31:0] mul_x, mul_y;
	logic signed [63:0] mul_p;
	logic signed [65:0] num_a, num_b;
	logic [64:0]        nmag_a, nmag_b;
	logic [47:0]        dmag;
	logic               dz;
	logic               step_a, step_b;
	logic signed [48:0] y_sum;
	logic signed [31:0] y_sat;

	function automatic logic signed [31:0] quo_final(input logic [31:0] q, input logic neg,
	                                                 input logic sat, input logic zr);
		logic signed [31:0] v;
		if (zr) begin
			v = '0;
		end else if (sat) begin
			v = neg ? S32_MIN : S32_MAX;
		end else if (neg) begin
			v = (q > 32'h80000000) ? S32_MIN : $signed(-q);
		end else begin
			v = q[31] ? S32_MAX : $signed(q);
		end
		return v;
	endfunction

	tbvs_ram #(
		.WIDTH(64),
		.DEPTH(MAX_NODES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata({res_a, res_b}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Node 0 is never stored: its slope is zero and its offset the left boundary.
	assign prev_a = (idx_q == IW'(1)) ? 32'sd0 : $signed(rd_data[63:32]);
	assign prev_b = (idx_q == IW'(1)) ? left_q : $signed(rd_data[31:0]);
	assign sel_a  = (bidx_q == '0) ? 32'sd0 : $signed(rd_data[63:32]);
	assign sel_b  = (bidx_q == '0) ? left_q : $signed(rd_data[31:0]);

	// One shared multiplier for both coefficient products and the back sweep.
	always_comb begin
		mul_x = $signed({1'b0, k_q});
		mul_y = prev_a;
		if (state_q == B_MULB) begin
			mul_y = prev_b;
		end else if (state_q == B_MULY) begin
			mul_x = sel_a;
			mul_y = back_q;
		end
	end
	assign mul_p = mul_x * mul_y;

	assign num_a  = -$signed({19'b0, k_q, 16'b0});
	assign num_b  = $signed({{18{rhs_q[31]}}, rhs_q, 16'b0}) - 66'(prod_q);
	assign nmag_a = num_a[65] ? 65'(-num_a) : num_a[64:0];
	assign nmag_b = num_b[65] ? 65'(-num_b) : num_b[64:0];
	assign dmag   = den_q[48] ? 48'(-den_q) : den_q[47:0];
	assign dz     = (den_q == '0);

	assign step_a = ({15'b0, rem_a_q} >= dsh_q);
	assign step_b = ({15'b0, rem_b_q} >= dsh_q);

	assign res_a = quo_final(quo_a_q, neg_a_q, sat_a_q, zr_a_q);
	assign res_b = quo_final(quo_b_q, neg_b_q, sat_b_q, zr_b_q);

	assign y_sum = 49'($signed(prod_q[63:16])) + 49'(sel_b);
	assign y_sat = (y_sum > 49'(S32_MAX)) ? S32_MAX :
	               (y_sum < 49'(S32_MIN)) ? S32_MIN : y_sum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		head_pop = 1'b0;
		ram_we   = 1'b0;
		rd_addr  = idx_q - IW'(1);
		unique case (state_q)
			B_IDLE: begin
				rd_addr = head_idx - IW'(1);
				if (head_valid) begin
					head_pop = 1'b1;
					state_d  = B_MULA;
				end
			end
			B_MULA: state_d = B_MULB;
			B_MULB: state_d = B_PREP;
			B_PREP: state_d = B_DIV;
			B_DIV: begin
				if (step_q == 5'd31) begin
					state_d = B_WR;
				end
			end
			B_WR: begin
				ram_we  = 1'b1;
				state_d = last_q ? B_RDY : B_IDLE;
			end
			B_RDY: begin
				rd_addr = bidx_q;
				state_d = B_MULY;
			end
			B_MULY: begin
				rd_addr = bidx_q;
				state_d = B_OUT;
			end
			B_OUT: begin
				rd_addr = bidx_q;
				state_d = (bidx_q == '0) ? B_IDLE : B_RDY;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= (state_q == B_OUT) || (state_q == B_WR && last_q);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					rhs_q  <= head_rhs;
					idx_q  <= head_idx;
					last_q <= head_last;
					k_q    <= cfg.inv_step_squared;
					if (head_idx == IW'(1)) begin
						left_q <= cfg.left_boundary;
					end
					if (head_last) begin
						right_q <= cfg.right_boundary;
					end
				end
			end
			B_MULA: prod_q <= mul_p;
			B_MULB: begin
				prod_q <= mul_p;
				den_q  <= 49'($signed(prod_q[63:16])) - $signed({17'b0, k_q, 1'b0});
			end
			B_PREP: begin
				rem_a_q <= nmag_a;
				rem_b_q <= nmag_b;
				dsh_q   <= {1'b0, dmag, 31'b0};
				step_q  <= '0;
				zr_a_q  <= (nmag_a == '0);
				zr_b_q  <= (nmag_b == '0);
				sat_a_q <= ({15'b0, nmag_a} >= {dmag, 32'b0});
				sat_b_q <= ({15'b0, nmag_b} >= {dmag, 32'b0});
				neg_a_q <= num_a[65] ^ (den_q[48] && !dz);
				neg_b_q <= num_b[65] ^ (den_q[48] && !dz);
			end
			B_DIV: begin
				if (step_a) begin
					rem_a_q <= rem_a_q - dsh_q[64:0];
				end
				if (step_b) begin
					rem_b_q <= rem_b_q - dsh_q[64:0];
				end
				quo_a_q <= {quo_a_q[30:0], step_a};
				quo_b_q <= {quo_b_q[30:0], step_b};
				dsh_q   <= dsh_q >> 1;
				step_q  <= step_q + 5'd1;
			end
			B_WR: begin
				back_q                <= right_q;
				bidx_q                <= idx_q;
				result.node_number    <= NODE_W'(idx_q + IW'(1));
				result.solution_value <= right_q;
				result.run_end        <= 1'b0;
			end
			B_RDY: ;
			B_MULY: prod_q <= mul_p;
			B_OUT: begin
				back_q                <= y_sat;
				bidx_q                <= bidx_q - IW'(1);
				result.node_number    <= NODE_W'(bidx_q);
				result.solution_value <= y_sat;
				result.run_end        <= (bidx_q == '0);
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/tridiagonal_boundary_value_solver_core.sv]
// Channel   Handshake                     Payload             Direction
// input     start, accepted when !busy    in_item (in_item_t) into core
// result    result_strobe, one cycle      result (result_t)   out of core
// config    cfg_we, cfg_index             cfg_data            into core
//
// Each interior sample passes in order through the back end: a queue pop,
// the two coefficient products on the shared multiplier, a set-up step, the
// two parallel restoring dividers (slope and offset share one denominator)
// and a store. A closing sample then emits n+2 results, each after the first
// paced by the read, multiply and accumulate of the back substitution through
// the store. The receiver cannot stall; a two-entry queue lets start be taken
// while the back end works. Reset is asynchronous and needs no clearing pass.
module tridiagonal_boundary_value_solver_core #(
	parameter int MAX_NODES = tbvs_pkg::MAX_NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  tbvs_pkg::in_item_t                in_item,
	output logic                              result_strobe,
	output tbvs_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [tbvs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tbvs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tbvs_pkg::*;

	localparam int IW = $clog2(MAX_NODES);

	cfg_t               cfg_q;
	logic               head_valid;
	logic signed [31:0] head_rhs;
	logic [IW-1:0]      head_idx;
	logic               head_last;
	logic               head_pop;

	// Configuration registers. An index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_step_squared <= INV_STEP_SQUARED_RST;
			cfg_q.left_boundary    <= LEFT_BOUNDARY_RST;
			cfg_q.right_boundary   <= RIGHT_BOUNDARY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INV_STEP_SQUARED: cfg_q.inv_step_squared <= cfg_data[30:0];
				CFG_LEFT_BOUNDARY:    cfg_q.left_boundary    <= $signed(cfg_data);
				CFG_RIGHT_BOUNDARY:   cfg_q.right_boundary   <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// The front end numbers the interior nodes and decides which transaction
	// closes a problem, either on final_sample or at interior node MAX_NODES-2.
	tbvs_front #(
		.MAX_NODES(MAX_NODES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_item   (in_item),
		.head_valid(head_valid),
		.head_rhs  (head_rhs),
		.head_idx  (head_idx),
		.head_last (head_last),
		.head_pop  (head_pop)
	);

	// The back end runs the forward elimination step and, on a closing
	// transaction, the back substitution from the right boundary down to node 0.
	tbvs_back #(
		.MAX_NODES(MAX_NODES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head_rhs     (head_rhs),
		.head_idx     (head_idx),
		.head_last    (head_last),
		.head_pop     (head_pop),
		.result_strobe(result_strobe),
		.result       (result)
	);

endmodule
